// ===== rtl/gkx_pkg.sv =====
// Shared types, register indexes and key tables for the generated-key XOR cipher.
`default_nettype none
package gkx_pkg;

   localparam int TABLE_BYTES = 64;
   localparam int ROW_LEN     = TABLE_BYTES + 1;

   localparam int ROW_W  = 6;
   localparam int COL_W  = 7;
   localparam int DATA_W = 8;
   localparam int OFS_W  = 13;
   localparam int REG_W  = 24;
   localparam int IDX_W  = 2;

   localparam logic [IDX_W-1:0] CSR_KEY_OFFSET   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_REGION_START = 2'd1;
   localparam logic [IDX_W-1:0] CSR_BYPASS       = 2'd2;

   localparam logic [COL_W-1:0] LAST_COL = 7'd64;

   localparam logic [DATA_W-1:0] ROW_MASK [TABLE_BYTES] = '{
      8'h41, 8'hCA, 8'h42, 8'hF9, 8'h3C, 8'h6D, 8'h9D, 8'hDF,
      8'hD8, 8'h19, 8'h84, 8'h08, 8'h50, 8'hFB, 8'h67, 8'hA1,
      8'hAD, 8'h35, 8'hF2, 8'hCE, 8'hDF, 8'h9A, 8'hF3, 8'hC4,
      8'hF5, 8'h22, 8'h1A, 8'h8A, 8'hD5, 8'h64, 8'h08, 8'h65,
      8'hD3, 8'h2C, 8'h96, 8'hB6, 8'h08, 8'h11, 8'h3A, 8'hB3,
      8'h90, 8'h08, 8'hE6, 8'h2E, 8'h88, 8'hED, 8'h24, 8'hFB,
      8'h24, 8'h28, 8'h82, 8'h3D, 8'h39, 8'hA8, 8'hF3, 8'h52,
      8'h98, 8'hF9, 8'hA7, 8'h75, 8'h52, 8'h63, 8'h0A, 8'hF9
   };

   localparam logic [DATA_W-1:0] COL_MASK [ROW_LEN] = '{
      8'hA5, 8'hF5, 8'h2A, 8'hBE, 8'h62, 8'h66, 8'h1C, 8'h80,
      8'h87, 8'h3F, 8'h91, 8'h01, 8'h6E, 8'hBC, 8'h87, 8'h02,
      8'hD0, 8'h2A, 8'h3A, 8'hC4, 8'h65, 8'h3C, 8'h91, 8'h35,
      8'hB5, 8'hAE, 8'h21, 8'h21, 8'hF5, 8'h3F, 8'hAC, 8'h1F,
      8'hBE, 8'h92, 8'hA6, 8'hF2, 8'hA8, 8'h42, 8'h39, 8'h8F,
      8'h41, 8'h95, 8'h91, 8'hBD, 8'h4C, 8'hAD, 8'h85, 8'hC7,
      8'hB7, 8'hD6, 8'hAE, 8'h1C, 8'hE2, 8'h62, 8'hEB, 8'hC2,
      8'h03, 8'h5D, 8'hD6, 8'h4E, 8'h7B, 8'h59, 8'h0F, 8'hDD,
      8'hB7
   };

   typedef struct packed {
      logic [ROW_W-1:0] start_row;
      logic [COL_W-1:0] start_col;
      logic             bypass;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/gkx_csr.sv =====
// Configuration registers and the registered start position of the key stream.
`default_nettype none
module gkx_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [gkx_pkg::IDX_W-1:0] csr_index,
   input  wire logic [gkx_pkg::REG_W-1:0] csr_wdata,
   output gkx_pkg::cfg_type               cfg
);
   import gkx_pkg::*;

   logic [OFS_W-1:0] key_offset_ff, key_offset_in;
   logic [REG_W-1:0] region_start_ff, region_start_in;
   logic             bypass_ff, bypass_in;
   logic [ROW_W-1:0] start_row_ff, start_row_in;
   logic [COL_W-1:0] start_col_ff, start_col_in;

   logic [REG_W:0]   sum;
   logic [18:0]      quot;
   logic signed [8:0] alt;
   logic [COL_W-1:0] m;
   logic [COL_W-1:0] low;

   always_comb begin
      key_offset_in   = key_offset_ff;
      region_start_in = region_start_ff;
      bypass_in       = bypass_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_OFFSET:   key_offset_in   = csr_wdata[OFS_W-1:0];
            CSR_REGION_START: region_start_in = csr_wdata;
            CSR_BYPASS:       bypass_in       = csr_wdata[0];
            default:          ;
         endcase
      end
   end

   // sum = 64*quot + low; 64 = -1 mod 65, so quot mod 65 is an alternating
   // sum of its 6-bit digits. Then p = 64*m + low = 65*m + (low - m).
   always_comb begin
      sum  = {{(REG_W+1-OFS_W){1'b0}}, key_offset_ff} + {1'b0, region_start_ff};
      quot = sum[REG_W:6];
      alt  = $signed({3'b000, quot[5:0]}) + $signed({3'b000, quot[17:12]})
           - $signed({3'b000, quot[11:6]}) - $signed({8'b0, quot[18]});
      if (alt < 0) begin
         m = COL_W'(alt + 9'sd65);
      end else if (alt >= 9'sd65) begin
         m = COL_W'(alt - 9'sd65);
      end else begin
         m = COL_W'(alt);
      end
      low = {1'b0, sum[5:0]};
      if (low >= m) begin
         start_row_in = m[ROW_W-1:0];
         start_col_in = low - m;
      end else begin
         start_row_in = ROW_W'(m - 7'd1);
         start_col_in = low + 7'd65 - m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_offset_ff   <= '0;
         region_start_ff <= '0;
         bypass_ff       <= 1'b0;
         start_row_ff    <= '0;
         start_col_ff    <= '0;
      end else begin
         key_offset_ff   <= key_offset_in;
         region_start_ff <= region_start_in;
         bypass_ff       <= bypass_in;
         start_row_ff    <= start_row_in;
         start_col_ff    <= start_col_in;
      end
   end

   assign cfg.start_row = start_row_ff;
   assign cfg.start_col = start_col_ff;
   assign cfg.bypass    = bypass_ff;

endmodule
`default_nettype wire

// ===== rtl/gkx_keystream.sv =====
// Key position counters, key byte generation and the XOR (or bypass) of one data word.
`default_nettype none
module gkx_keystream (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       first,
   input  wire logic [gkx_pkg::DATA_W-1:0] data_byte,
   input  gkx_pkg::cfg_type                cfg,
   output logic [gkx_pkg::DATA_W-1:0]      out_byte
);
   import gkx_pkg::*;

   logic [ROW_W-1:0]  key_row_ff, key_row_in;
   logic [COL_W-1:0]  key_col_ff, key_col_in;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  mix_idx;
   logic [DATA_W-1:0] key_byte;

   always_comb begin
      cur_row  = first ? cfg.start_row : key_row_ff;
      cur_col  = first ? cfg.start_col : key_col_ff;
      mix_idx  = cur_row + cur_col[ROW_W-1:0];
      key_byte = COL_MASK[cur_col] ^ ROW_MASK[mix_idx];
      out_byte = cfg.bypass ? data_byte : (data_byte ^ key_byte);

      key_row_in = key_row_ff;
      key_col_in = key_col_ff;
      if (advance) begin
         if (cur_col == LAST_COL) begin
            key_col_in = '0;
            key_row_in = cur_row + 6'd1;
         end else begin
            key_col_in = cur_col + 7'd1;
            key_row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_row_ff <= '0;
         key_col_ff <= '0;
      end else begin
         key_row_ff <= key_row_in;
         key_col_ff <= key_col_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/generated_key_xor_stream_cipher.sv =====
// Top level of the generated-key XOR stream cipher: handshake, stages, config.
// Pipeline: two stages, the input register and the result register; the XOR is
//   combinational from the input register into the result register.
// Throughput: one word per cycle while rsp_stall is low; the input register and result
//   register let a new word in while a finished word waits under rsp_stall.
// Reset (synchronous, active high) clears config, key position and valid bits.
`default_nettype none
module generated_key_xor_stream_cipher (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [gkx_pkg::DATA_W-1:0] req_data_byte,
   input  wire logic                       req_first,
   input  wire logic                       req_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [gkx_pkg::DATA_W-1:0]      rsp_out_byte,
   output logic                            rsp_last_out,
   input  wire logic                       csr_we,
   input  wire logic [gkx_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [gkx_pkg::REG_W-1:0]  csr_wdata
);
   import gkx_pkg::*;

   cfg_type cfg;

   // Input stage: hold the accepted word until the result register frees up.
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_data_ff, in_data_in;
   logic              in_first_ff, in_first_in;
   logic              in_last_ff, in_last_in;

   // Result stage.
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              move;
   logic              req_take;
   logic [DATA_W-1:0] coded_byte;

   gkx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Advance the key position only when the word really moves to the result.
   gkx_keystream u_keystream (
      .clock     (clock),
      .reset     (reset),
      .advance   (move),
      .first     (in_first_ff),
      .data_byte (in_data_ff),
      .cfg       (cfg),
      .out_byte  (coded_byte)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      move      = in_valid_ff && out_free;
      // Stall only when the input stage is full and cannot drain this cycle.
      req_stall = in_valid_ff && !out_free;
      req_take  = req_valid && !req_stall;

      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_first_in = in_first_ff;
      in_last_in  = in_last_ff;
      if (move) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
         in_first_in = req_first;
         in_last_in  = req_last;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_byte_in = coded_byte;
            out_last_in = in_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_first_ff <= in_first_in;
      in_last_ff  <= in_last_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last_out = out_last_ff;

endmodule
`default_nettype wire
